// ===== src/assert_macros.svh =====
// assertion macros used by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define U8D_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/u8d_pkg.sv =====
// shared types and constants of the utf-8 stream decoder
package u8d_pkg;

    localparam logic [7:0] ASCII_MAX = 8'd127;
    localparam logic [7:0] LEAD2_MIN = 8'd192;
    localparam logic [7:0] LEAD2_MAX = 8'd223;
    localparam logic [7:0] LEAD3_MAX = 8'd239;
    localparam logic [7:0] LEAD4_MAX = 8'd247;
    localparam logic [7:0] LEAD_SURR = 8'hED;
    localparam logic [7:0] SURR_BITS = 8'hA0;

    // lead class of one byte
    typedef struct packed {
        logic       bad;
        logic       is_ed;
        logic [2:0] need;
    } t_cls;

    localparam t_cls CLS_NONE = '{bad: 1'b1, is_ed: 1'b0, need: 3'd1};

    // one queued word
    typedef struct packed {
        logic [7:0] data;
        t_cls       cls;
        logic       last;
    } t_q_item;

    // decoder status seen at the top
    typedef struct packed {
        logic busy;
        logic emit;
    } t_back_status;

endpackage

// ===== src/u8d_front.sv =====
// input side: accepts words, classifies the lead byte and queues them
module u8d_front
    import u8d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    input  logic       i_last_byte,
    output logic       o_q_valid,
    output t_q_item    o_q_item,
    input  logic       i_q_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_q_item       r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    t_cls          cls;

    always_comb begin
        cls = '{bad: 1'b0, is_ed: 1'b0, need: 3'd1};
        if (i_byte_in <= ASCII_MAX) begin
            cls.need = 3'd1;
        end else if (i_byte_in < LEAD2_MIN || i_byte_in > LEAD4_MAX) begin
            cls.bad = 1'b1;
        end else if (i_byte_in <= LEAD2_MAX) begin
            cls.need = 3'd2;
        end else if (i_byte_in <= LEAD3_MAX) begin
            cls.need = 3'd3;
            cls.is_ed = (i_byte_in == LEAD_SURR);
        end else begin
            cls.need = 3'd4;
        end
    end

    assign o_stall   = (r_cnt == CW'(DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{data: i_byte_in, cls: cls, last: i_last_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/u8d_back.sv =====
// decode side: holds the open sequence and issues one result per cycle while the output is not stalled
module u8d_back
    import u8d_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_q_item      i_q_item,
    output logic         o_q_pop,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [20:0]  o_code_point,
    output logic         o_error,
    output logic [2:0]   o_bytes_consumed,
    output logic         o_end_of_run,
    output t_back_status o_status
);

    // true when the sequence at the head can be resolved now
    function automatic logic dec_ok(input t_cls c, input logic [7:0] b1,
                                    input logic [2:0] cnt, input logic fin);
        logic ok;
        begin
            ok = 1'b1;
            if (!c.bad && c.need != 3'd1) begin
                if (c.is_ed && cnt < 3'd2) begin
                    ok = fin;
                end else if (c.is_ed && (b1 & SURR_BITS) == SURR_BITS) begin
                    ok = 1'b1;
                end else if (cnt < c.need) begin
                    ok = fin;
                end
            end
            return ok;
        end
    endfunction

    logic [7:0]  r_buf [4];
    t_cls        r_cls [4];
    logic [2:0]  r_cnt;
    logic        r_fin;
    logic        r_busy;
    logic        r_out_valid;
    logic [20:0] r_cp;
    logic        r_err;
    logic [2:0]  r_used;
    logic        r_end;

    logic [7:0]  v_buf [4];
    t_cls        v_cls [4];
    logic [2:0]  v_cnt;
    logic        v_fin;
    logic [7:0]  rest_buf [4];
    t_cls        rest_cls [4];
    logic [2:0]  rest_cnt;
    logic        have_work;
    logic        ok;
    logic        surr;
    logic        err;
    logic [2:0]  used;
    logic [20:0] cp;
    logic        more;
    logic        out_free;
    logic        emit;

    always_comb begin
        v_buf = r_buf;
        v_cls = r_cls;
        v_cnt = r_cnt;
        v_fin = r_fin;
        if (!r_busy) begin
            v_buf[r_cnt[1:0]] = i_q_item.data;
            v_cls[r_cnt[1:0]] = i_q_item.cls;
            v_cnt             = r_cnt + 3'd1;
            v_fin             = i_q_item.last;
        end

        have_work = r_busy || i_q_valid;
        ok   = dec_ok(v_cls[0], v_buf[1], v_cnt, v_fin);
        surr = v_cls[0].is_ed && (v_cnt >= 3'd2) && ((v_buf[1] & SURR_BITS) == SURR_BITS);
        err  = v_cls[0].bad || surr || (v_cnt < v_cls[0].need);
        used = err ? 3'd1 : v_cls[0].need;

        case (used)
            3'd2:    cp = {10'd0, v_buf[0][4:0], v_buf[1][5:0]};
            3'd3:    cp = {5'd0, v_buf[0][3:0], v_buf[1][5:0], v_buf[2][5:0]};
            3'd4:    cp = {v_buf[0][2:0], v_buf[1][5:0], v_buf[2][5:0], v_buf[3][5:0]};
            default: cp = {13'd0, v_buf[0]};
        endcase
        if (err) begin
            cp = '0;
        end

        // slide the leftover bytes down to the head
        rest_buf = v_buf;
        rest_cls = v_cls;
        case (used)
            3'd1: begin
                rest_buf[0] = v_buf[1];
                rest_buf[1] = v_buf[2];
                rest_buf[2] = v_buf[3];
                rest_cls[0] = v_cls[1];
                rest_cls[1] = v_cls[2];
                rest_cls[2] = v_cls[3];
            end
            3'd2: begin
                rest_buf[0] = v_buf[2];
                rest_buf[1] = v_buf[3];
                rest_cls[0] = v_cls[2];
                rest_cls[1] = v_cls[3];
            end
            3'd3: begin
                rest_buf[0] = v_buf[3];
                rest_cls[0] = v_cls[3];
            end
            default: begin
                rest_cls[0] = CLS_NONE;
            end
        endcase
        rest_cnt = v_cnt - used;
        more     = (rest_cnt != 3'd0) && dec_ok(rest_cls[0], rest_buf[1], rest_cnt, v_fin);

        out_free = !r_out_valid || !i_stall;
        emit     = have_work && ok && out_free;
        o_q_pop  = !r_busy && i_q_valid && (!ok || out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_cnt  <= rest_cnt;
                r_busy <= more;
            end else if (o_q_pop) begin
                r_cnt  <= v_cnt;
                r_busy <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_buf  <= rest_buf;
            r_cls  <= rest_cls;
            r_fin  <= v_fin;
            r_cp   <= cp;
            r_err  <= err;
            r_used <= used;
            r_end  <= !more;
        end else if (o_q_pop) begin
            r_buf <= v_buf;
            r_cls <= v_cls;
            r_fin <= v_fin;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_code_point     = r_cp;
    assign o_error          = r_err;
    assign o_bytes_consumed = r_used;
    assign o_end_of_run     = r_end;
    assign o_status         = '{busy: r_busy, emit: emit};

endmodule

// ===== src/utf8_stream_decoder_top.sv =====
// utf-8 stream decoder: raw string bytes in, code points out
// input channel: i_valid / o_stall carry one word per accept, i_byte_in with
// i_last_byte high on the final byte of a string
// output channel: o_valid / i_stall carry one result word: o_code_point,
// o_error (code point then zero), o_bytes_consumed (1..4) and o_end_of_run,
// which marks the last result caused by an input word
// a word that only extends an open sequence gives no result; a surrogate
// lead gives an error and its second byte restarts as a fresh lead; at the
// end of a string an open sequence reports its lead as an error and the
// held bytes after it are decoded again, so one word can give up to four
// results
// an accepted word lands in the QUEUE_DEPTH word queue at the accept edge;
// the decoder registers any result it gives in the output register
// while the output is not stalled, the decoder retires one result or one
// absorbed word per cycle; the queue buffers words and o_stall rises only
// when it is full; i_stall holds the output register and, once a result
// waits, the decoder issues no more results but still absorbs words that
// give none; reset (synchronous, active low) empties the queue, drops the
// open sequence and clears o_valid; no clearing pass is needed
`include "assert_macros.svh"

module utf8_stream_decoder_top
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic        o_error,
    output logic [2:0]  o_bytes_consumed,
    output logic        o_end_of_run
);

    // queue head towards the decoder
    logic         q_valid;
    t_q_item      q_item;
    logic         q_pop;
    t_back_status back_st;

    // front: classify and queue incoming words
    u8d_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_byte_in   (i_byte_in),
        .i_last_byte (i_last_byte),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    // back: assemble sequences and issue results
    u8d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_point     (o_code_point),
        .o_error          (o_error),
        .o_bytes_consumed (o_bytes_consumed),
        .o_end_of_run     (o_end_of_run),
        .o_status         (back_st)
    );

    // an error result carries no code point and only its lead byte
    `U8D_ASSERT_IMP(a_err_clean, i_clk, i_rst_n, o_valid && o_error, (o_code_point == 21'd0) && (o_bytes_consumed == 3'd1), "error result not clean")

    // a single-byte result is plain ascii
    `U8D_ASSERT_IMP(a_one_byte, i_clk, i_rst_n, o_valid && !o_error && (o_bytes_consumed == 3'd1), o_code_point <= 21'd127, "single byte result out of range")

    // a result that is not the last of its word leaves the decoder busy
    `U8D_ASSERT_IMP(a_run_open, i_clk, i_rst_n, o_valid && !o_end_of_run, back_st.busy, "open run with idle decoder")

    // a decoded result shows on the output in the next cycle
    `U8D_ASSERT_NEXT(a_emit_shown, i_clk, i_rst_n, back_st.emit, o_valid, "issued result lost")

endmodule

// ===== bench/utf8_stream_decoder_top_tb.sv =====
// self-checking bench for the utf-8 stream decoder top level
module utf8_stream_decoder_top_tb;
    import u8d_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 105;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_RESULTS  = 4;
    localparam int CALM_STRETCH = 60;
    localparam int N_DIRECTED   = 25;

    // one string byte waiting to be sent; burst words are sent back to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       burst;
    } str_word_t;

    // one predicted decoder result
    typedef struct packed {
        logic [20:0] code_point;
        logic        error;
        logic [2:0]  bytes_used;
        logic        end_of_run;
    } decoded_t;

    // held bytes plus the new byte, at most four in view
    typedef logic [7:0] byte_win_t [4];

    // directed words, bit 8 is the end-of-string flag
    localparam logic [8:0] DIRECTED_WORDS [N_DIRECTED] = '{
        9'h000, 9'h17F,                 // lowest and highest ascii
        9'h0C2, 9'h1A9,                 // two-byte sequence
        9'h0E2, 9'h082, 9'h1AC,         // three-byte sequence
        9'h0ED, 9'h09F, 9'h1BF,         // 0xed lead that is not a surrogate
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF, // largest four-byte value
        9'h080, 9'h1FF,                 // bad leads at both ends
        9'h0ED, 9'h0A0, 9'h180,         // surrogate, then two stray tails
        9'h0E2, 9'h182,                 // three-byte cut short by end of string
        9'h0F0, 9'h0C3, 9'h1A9,         // cut four-byte, tail re-decodes valid
        9'h1ED                          // lone 0xed at end of string
    };

    // dut ports; the inputs are known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_byte_in   = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [20:0] o_code_point;
    logic        o_error;
    logic [2:0]  o_bytes_consumed;
    logic        o_end_of_run;

    // stimulus and prediction state
    str_word_t   string_words_q [$];
    decoded_t    decoded_q [$];
    str_word_t   next_word;
    decoded_t    want;
    logic [7:0]  held_bytes [3];
    int unsigned held_cnt       = 0;
    int unsigned words_accepted = 0;
    int unsigned total_words    = 0;
    int unsigned mismatch_cnt   = 0;
    int unsigned send_wait      = 0;
    int unsigned stall_left     = 0;
    int unsigned calm_left      = 0;
    int unsigned stall_len;
    int unsigned idle_cycles    = 0;

    utf8_stream_decoder_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_byte_in        (i_byte_in),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_point     (o_code_point),
        .o_error          (o_error),
        .o_bytes_consumed (o_bytes_consumed),
        .o_end_of_run     (o_end_of_run)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // try one sequence starting at win[p]; returns 0 when more bytes are needed
    function automatic bit decode_at(input byte_win_t win, input int unsigned p,
                                     input int unsigned avail, input bit fin,
                                     output decoded_t r);
        logic [7:0]  lead;
        int unsigned need;
        lead = win[p];
        r = '{code_point: '0, error: 1'b1, bytes_used: 3'd1, end_of_run: 1'b0};
        if (lead <= ASCII_MAX) begin
            r.code_point = 21'(lead);
            r.error = 1'b0;
            return 1'b1;
        end
        // continuation byte or beyond the four-byte range: bad lead
        if (lead < LEAD2_MIN || lead > LEAD4_MAX)
            return 1'b1;
        if (lead <= LEAD2_MAX)
            need = 2;
        else if (lead <= LEAD3_MAX)
            need = 3;
        else
            need = 4;
        // surrogate half: report the lead alone, the second byte starts afresh
        if (lead == LEAD_SURR) begin
            if (avail < 2)
                return fin;
            if ((win[p + 1] & SURR_BITS) == SURR_BITS)
                return 1'b1;
        end
        // incomplete: hold, unless the string has ended
        if (avail < need)
            return fin;
        case (need)
            2: r.code_point = 21'({lead[4:0], win[p + 1][5:0]});
            3: r.code_point = 21'({lead[3:0], win[p + 1][5:0], win[p + 2][5:0]});
            default: begin
                r.code_point = {lead[2:0], win[p + 1][5:0], win[p + 2][5:0],
                                win[p + 3][5:0]};
            end
        endcase
        r.error = 1'b0;
        r.bytes_used = 3'(need);
        return 1'b1;
    endfunction

    // works out every result one accepted word causes and updates the held bytes
    task automatic decode_word(input logic [7:0] b, input logic fin);
        byte_win_t   win;
        decoded_t    res [MAX_RESULTS];
        int unsigned n, pos, cnt, i;
        bit          waiting;
        n = 0;
        pos = 0;
        cnt = 0;
        waiting = 1'b0;
        for (i = 0; i < held_cnt; i++) begin
            win[n] = held_bytes[i];
            n++;
        end
        win[n] = b;
        n++;
        while (!waiting && pos < n && cnt < MAX_RESULTS) begin
            if (decode_at(win, pos, n - pos, fin, res[cnt])) begin
                pos += res[cnt].bytes_used;
                cnt++;
            end else begin
                waiting = 1'b1;
            end
        end
        for (i = 0; i < cnt; i++) begin
            res[i].end_of_run = (i == cnt - 1);
            decoded_q.push_back(res[i]);
        end
        held_cnt = n - pos;
        if (held_cnt > 3)
            held_cnt = 3;
        for (i = 0; i < held_cnt; i++)
            held_bytes[i] = win[pos + i];
    endtask

    // mostly a proper continuation byte, now and then anything at all
    function automatic logic [7:0] tail_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        return {2'b10, 6'($urandom)};
    endfunction

    // idle length: mostly none, often short, rarely long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one random string: mostly well-formed characters with random content,
    // mixed with surrogates, bad leads, noise and a cut final character
    task automatic add_random_string();
        logic [7:0]  chunk [$];
        logic [7:0]  lead;
        int unsigned chars, kind, need, start, i, j;
        bit          burst;
        burst = ($urandom_range(0, 3) == 0);
        chars = $urandom_range(1, 6);
        for (i = 0; i < chars; i++) begin
            kind = $urandom_range(0, 11);
            need = 1;
            case (kind)
                0, 1, 2: lead = 8'($urandom_range(0, 127));
                3, 4: begin
                    lead = 8'($urandom_range(192, 223));
                    need = 2;
                end
                5, 6: begin
                    lead = 8'($urandom_range(224, 239));
                    need = 3;
                end
                7: begin
                    lead = 8'($urandom_range(240, 247));
                    need = 4;
                end
                8, 11: begin
                    lead = LEAD_SURR;
                    need = 3;
                end
                9: begin
                    if ($urandom_range(0, 1) == 0)
                        lead = 8'($urandom_range(128, 191));
                    else
                        lead = 8'($urandom_range(248, 255));
                end
                default: lead = 8'($urandom);
            endcase
            start = chunk.size();
            chunk.push_back(lead);
            for (j = 1; j < need; j++)
                chunk.push_back(tail_byte());
            // force both surrogate bits on the second byte
            if (kind == 8)
                chunk[start + 1] = {1'b1, 1'($urandom), 1'b1, 5'($urandom)};
            // string ends inside the last character now and then
            if (i == chars - 1 && need > 1 && $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, need - 1))
                    void'(chunk.pop_back());
            end
        end
        for (j = 0; j < chunk.size(); j++)
            string_words_q.push_back('{data: chunk[j], last: (j == chunk.size() - 1),
                                       burst: burst});
    endtask

    // input driver: presents queued words, holds them while stalled, and
    // predicts the results of each word as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait <= 0;
            held_cnt = 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                decode_word(i_byte_in, i_last_byte);
                words_accepted <= words_accepted + 1;
            end
            if (send_wait != 0) begin
                // gap after the previous word
                i_valid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (string_words_q.size() != 0) begin
                next_word = string_words_q.pop_front();
                i_valid <= 1'b1;
                i_byte_in <= next_word.data;
                i_last_byte <= next_word.last;
                send_wait <= next_word.burst ? 0 : idle_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output monitor: checks each accepted result against the oldest
    // prediction, and drives the receiver's stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
            calm_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result code_point %h error %b bytes %0d eor %b",
                             $time, o_code_point, o_error, o_bytes_consumed,
                             o_end_of_run);
                    mismatch_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_code_point !== want.code_point) begin
                        $display("%0t: code_point expected %h got %h",
                                 $time, want.code_point, o_code_point);
                        mismatch_cnt++;
                    end
                    if (o_error !== want.error) begin
                        $display("%0t: error expected %b got %b",
                                 $time, want.error, o_error);
                        mismatch_cnt++;
                    end
                    if (o_bytes_consumed !== want.bytes_used) begin
                        $display("%0t: bytes_consumed expected %0d got %0d",
                                 $time, want.bytes_used, o_bytes_consumed);
                        mismatch_cnt++;
                    end
                    if (o_end_of_run !== want.end_of_run) begin
                        $display("%0t: end_of_run expected %b got %b",
                                 $time, want.end_of_run, o_end_of_run);
                        mismatch_cnt++;
                    end
                end
            end
            // stall in runs, with the odd stretch of no stalling at all
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (calm_left != 0) begin
                i_stall <= 1'b0;
                calm_left <= calm_left - 1;
            end else if ($urandom_range(0, 49) == 0) begin
                i_stall <= 1'b0;
                calm_left <= CALM_STRETCH;
            end else begin
                stall_len = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
                i_stall <= (stall_len != 0);
                stall_left <= (stall_len != 0) ? stall_len - 1 : 0;
            end
        end
    end

    // watchdog: too long without a word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        for (int k = 0; k < N_DIRECTED; k++)
            string_words_q.push_back('{data: DIRECTED_WORDS[k][7:0],
                                       last: DIRECTED_WORDS[k][8], burst: 1'b0});
        while (string_words_q.size() < N_DIRECTED + RANDOM_WORDS)
            add_random_string();
        total_words = string_words_q.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every word in, then every predicted result out, then a short drain
        while (words_accepted != total_words)
            @(posedge i_clk);
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
